FILE: design/i2cm_pkg.sv
// package: phase and primitive codes, operation codes and register indexes of the i2c master
package i2cm_pkg;

    // operation codes carried in the input word's tuser
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_REG_WRITE   = 3'd1;
    localparam logic [2:0] OP_REG_READ    = 3'd2;
    localparam logic [2:0] OP_BURST_WRITE = 3'd3;
    localparam logic [2:0] OP_BURST_READ  = 3'd4;
    localparam logic [2:0] OP_LOAD        = 3'd5;

    // configuration register indexes
    localparam logic CFG_WRITE_ADDR = 1'b0;
    localparam logic CFG_READ_ADDR  = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START1, PH_ADDR, PH_ADDR_ACK, PH_REG, PH_REG_ACK,
        PH_DATA, PH_DATA_ACK, PH_MIDSTOP, PH_START2, PH_RADDR,
        PH_RADDR_ACK, PH_READ, PH_MACK, PH_NAK, PH_STOP
    } phase_t;

    typedef enum logic [2:0] {
        PR_START, PR_WRITE, PR_CHECK, PR_READ, PR_SEND, PR_STOP
    } prim_t;

    function automatic prim_t prim_of(input phase_t ph);
        prim_t p;
        p = PR_STOP;
        unique case (ph)
            PH_START1, PH_START2:                          p = PR_START;
            PH_ADDR, PH_REG, PH_DATA, PH_RADDR:            p = PR_WRITE;
            PH_ADDR_ACK, PH_REG_ACK, PH_DATA_ACK,
            PH_RADDR_ACK:                                  p = PR_CHECK;
            PH_READ:                                       p = PR_READ;
            PH_MACK, PH_NAK:                               p = PR_SEND;
            PH_IDLE, PH_MIDSTOP, PH_STOP:                  p = PR_STOP;
            default:                                       p = PR_STOP;
        endcase
        return p;
    endfunction

endpackage

FILE: design/i2c_master_register_access_core.sv
// i2c master core: tick-driven scl/sda sequencer with register and burst accesses
//
// Each input word is one bus timing tick and yields exactly one output word giving the
// driven scl/sda levels after that tick plus busy, received-byte, acknowledge and stop
// flags. One word is taken per clock cycle; the sequencer state sits in flip-flops and
// the burst bytes sit in a BURST_DEPTH x 8 buffer memory with a registered read port.
// The next burst byte to send is fetched during the acknowledge check of the previous
// byte (three ticks long), so the registered read is always ready by the time the data
// phase starts and the buffer never stalls the stream. The output word is held in a
// register: s_tready stays high while that register is empty or being drained, so the
// sequencer stalls while a result waits for m_tready. A transaction starts on
// an operation 1 to 4 given while idle, and that word is already its first tick; any
// request given while busy acts as a plain tick. Burst bytes are loaded with operation
// 5 while idle, and bytes received by a burst read are stored into the buffer too.
// The two address registers are read when an address byte is first put on the bus.
// Timing in ticks: start 4, written bit 3, read bit 2, acknowledge/ack/nak 3, stop 3.
// Acknowledge bits are reported but never abort a transaction.
module i2c_master_register_access_core
    import i2cm_pkg::*;
#(
    parameter int BURST_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,       // 0 device write address, 1 device read address
    input  logic [7:0]  cfg_data,
    // input words, one per tick
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] slave_address, [14:7] register_address, [22:15] write_data,
    // [27:23] burst_length, [28] sda_in, [31:29] zero
    input  logic [31:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    // output words, one per tick
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] read_valid, [11:4] read_data,
    // [15:12] read_index, [16] ack_valid, [17] ack_level, [18] done_res, [23:19] zero
    output logic [23:0] m_tdata
);

    // counter wide enough to hold the depth itself, index just wide enough to address it
    localparam int BC_W  = $clog2(BURST_DEPTH + 1);
    localparam int IDX_W = (BURST_DEPTH > 1) ? $clog2(BURST_DEPTH) : 1;
    localparam logic [BC_W-1:0] DEPTH_BC = BC_W'(BURST_DEPTH);
    localparam logic [8:0]      DEPTH_9  = 9'(BURST_DEPTH);

    // configuration
    logic [7:0] dev_wr_addr_reg;
    logic [7:0] dev_rd_addr_reg;

    // sequencer state
    phase_t            phase_reg, phase_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic [1:0]        sub_reg, sub_next;
    logic [2:0]        bit_reg, bit_next;
    logic [BC_W-1:0]   byte_cnt_reg, byte_cnt_next;
    logic [7:0]        shift_reg, shift_next;
    logic [2:0]        kind_reg, kind_next;
    logic [6:0]        slave_reg, slave_next;
    logic [7:0]        regaddr_reg, regaddr_next;
    logic [7:0]        wdata_reg, wdata_next;
    logic [BC_W-1:0]   total_reg, total_next;
    logic [BC_W-1:0]   load_cnt_reg, load_cnt_next;

    // burst buffer
    logic [7:0]        buf_mem [BURST_DEPTH];
    logic [7:0]        buf_rd_data_reg;
    logic [IDX_W-1:0]  buf_rd_addr;
    logic              buf_wr_en;
    logic [IDX_W-1:0]  buf_wr_addr;
    logic [7:0]        buf_wr_data;

    // output word register
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;

    // input word fields
    logic [2:0] in_op;
    logic [6:0] in_slave;
    logic [7:0] in_reg;
    logic [7:0] in_wdata;
    logic [4:0] in_len;
    logic       in_sda;

    logic       step;

    // tick working values (after a possible start)
    phase_t          ph_c;
    logic [1:0]      sub_c;
    logic [2:0]      bit_c;
    logic [BC_W-1:0] bc_c;
    logic [7:0]      sh_c;
    logic [2:0]      kind_c;
    logic            busy_c;
    logic [BC_W:0]   bc_inc;
    logic            finished;

    // result flags
    logic            rd_valid;
    logic            ack_valid;
    logic            done_flag;
    logic [BC_W+3:0] bc_ext;
    logic [23:0]     out_word;

    assign in_op    = s_tuser;
    assign in_slave = s_tdata[6:0];
    assign in_reg   = s_tdata[14:7];
    assign in_wdata = s_tdata[22:15];
    assign in_len   = s_tdata[27:23];
    assign in_sda   = s_tdata[28];

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign step      = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // prefetch address: entry 0 during the register ack, else the byte after the current one
    assign bc_inc      = {1'b0, byte_cnt_reg} + 1'b1;
    assign buf_rd_addr = (phase_reg == PH_REG_ACK) ? '0 : bc_inc[IDX_W-1:0];

    // next state: start latch, one tick of the current primitive, phase advance
    always_comb
    begin
        logic [8:0]      len9;
        logic [BC_W:0]   bc_c_inc;
        phase_next    = phase_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        sub_next      = sub_reg;
        bit_next      = bit_reg;
        byte_cnt_next = byte_cnt_reg;
        shift_next    = shift_reg;
        kind_next     = kind_reg;
        slave_next    = slave_reg;
        regaddr_next  = regaddr_reg;
        wdata_next    = wdata_reg;
        total_next    = total_reg;
        load_cnt_next = load_cnt_reg;
        buf_wr_en     = 1'b0;
        buf_wr_addr   = load_cnt_reg[IDX_W-1:0];
        buf_wr_data   = in_wdata;
        finished      = 1'b0;
        len9          = {4'd0, in_len};

        ph_c   = phase_reg;
        sub_c  = sub_reg;
        bit_c  = bit_reg;
        bc_c   = byte_cnt_reg;
        sh_c   = shift_reg;
        kind_c = kind_reg;

        if (phase_reg == PH_IDLE)
        begin
            if (in_op == OP_LOAD)
            begin
                if (load_cnt_reg < DEPTH_BC)
                begin
                    buf_wr_en     = 1'b1;
                    load_cnt_next = load_cnt_reg + 1'b1;
                end
            end
            else if (in_op == OP_REG_WRITE || in_op == OP_REG_READ ||
                     in_op == OP_BURST_WRITE || in_op == OP_BURST_READ)
            begin
                kind_next    = in_op;
                slave_next   = in_slave;
                regaddr_next = in_reg;
                wdata_next   = in_wdata;
                if (in_len == 5'd0 || len9 > DEPTH_9)
                    total_next = DEPTH_BC;
                else
                    total_next = BC_W'(len9);
                if (in_op == OP_BURST_WRITE)
                    load_cnt_next = '0;
                ph_c   = PH_START1;
                sub_c  = 2'd0;
                bit_c  = 3'd0;
                bc_c   = '0;
                sh_c   = 8'd0;
                kind_c = in_op;
            end
        end

        busy_c   = (ph_c != PH_IDLE);
        bc_c_inc = {1'b0, bc_c} + 1'b1;

        phase_next    = ph_c;
        sub_next      = sub_c;
        bit_next      = bit_c;
        byte_cnt_next = bc_c;
        shift_next    = sh_c;

        if (busy_c)
        begin
            sub_next = sub_c + 2'd1;
            unique case (prim_of(ph_c))
                PR_START:
                begin
                    unique case (sub_c)
                        2'd0: sda_next = 1'b1;
                        2'd1: scl_next = 1'b1;
                        2'd2: sda_next = 1'b0;
                        default:
                        begin
                            scl_next = 1'b0;
                            finished = 1'b1;
                        end
                    endcase
                end
                PR_WRITE:
                begin
                    if (sub_c == 2'd0)
                        sda_next = sh_c[7];
                    else if (sub_c == 2'd1)
                        scl_next = 1'b1;
                    else
                    begin
                        scl_next   = 1'b0;
                        shift_next = {sh_c[6:0], 1'b0};
                        if (bit_c == 3'd7)
                            finished = 1'b1;
                        else
                        begin
                            bit_next = bit_c + 3'd1;
                            sub_next = 2'd0;
                        end
                    end
                end
                PR_CHECK, PR_SEND:
                begin
                    if (sub_c == 2'd0)
                        sda_next = (ph_c == PH_MACK) ? 1'b0 : 1'b1;
                    else if (sub_c == 2'd1)
                        scl_next = 1'b1;
                    else
                    begin
                        scl_next = 1'b0;
                        finished = 1'b1;
                    end
                end
                PR_READ:
                begin
                    if (sub_c == 2'd0)
                    begin
                        if (bit_c == 3'd0)
                            sda_next = 1'b1;
                        scl_next   = 1'b1;
                        shift_next = {sh_c[6:0], in_sda};
                        // received bytes of a burst read also land in the buffer
                        if (bit_c == 3'd7 && kind_c == OP_BURST_READ && bc_c < DEPTH_BC)
                        begin
                            buf_wr_en   = 1'b1;
                            buf_wr_addr = bc_c[IDX_W-1:0];
                            buf_wr_data = {sh_c[6:0], in_sda};
                        end
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        if (bit_c == 3'd7)
                            finished = 1'b1;
                        else
                        begin
                            bit_next = bit_c + 3'd1;
                            sub_next = 2'd0;
                        end
                    end
                end
                default:
                begin
                    if (sub_c == 2'd0)
                        sda_next = 1'b0;
                    else if (sub_c == 2'd1)
                        scl_next = 1'b1;
                    else
                    begin
                        sda_next = 1'b1;
                        finished = 1'b1;
                    end
                end
            endcase

            if (finished)
            begin
                sub_next   = 2'd0;
                bit_next   = 3'd0;
                shift_next = 8'd0;
                unique case (ph_c)
                    PH_START1:
                    begin
                        phase_next = PH_ADDR;
                        shift_next = (kind_c == OP_BURST_WRITE || kind_c == OP_BURST_READ)
                                     ? dev_wr_addr_reg : {slave_reg, 1'b0};
                        if (phase_reg == PH_IDLE)
                            shift_next = (kind_c == OP_BURST_WRITE ||
                                          kind_c == OP_BURST_READ)
                                         ? dev_wr_addr_reg : {in_slave, 1'b0};
                    end
                    PH_ADDR:     phase_next = PH_ADDR_ACK;
                    PH_ADDR_ACK:
                    begin
                        phase_next = PH_REG;
                        shift_next = regaddr_reg;
                    end
                    PH_REG:      phase_next = PH_REG_ACK;
                    PH_REG_ACK:
                    begin
                        byte_cnt_next = '0;
                        if (kind_c == OP_REG_WRITE)
                        begin
                            phase_next = PH_DATA;
                            shift_next = wdata_reg;
                        end
                        else if (kind_c == OP_BURST_WRITE)
                        begin
                            phase_next = PH_DATA;
                            shift_next = buf_rd_data_reg;
                        end
                        else if (kind_c == OP_REG_READ)
                            phase_next = PH_MIDSTOP;
                        else
                            phase_next = PH_START2;
                    end
                    PH_DATA:     phase_next = PH_DATA_ACK;
                    PH_DATA_ACK:
                    begin
                        byte_cnt_next = bc_c_inc[BC_W-1:0];
                        if (kind_c == OP_BURST_WRITE && bc_c_inc < {1'b0, total_reg})
                        begin
                            phase_next = PH_DATA;
                            shift_next = buf_rd_data_reg;
                        end
                        else
                            phase_next = PH_STOP;
                    end
                    PH_MIDSTOP:  phase_next = PH_START2;
                    PH_START2:
                    begin
                        phase_next = PH_RADDR;
                        shift_next = (kind_c == OP_REG_READ) ? {slave_reg, 1'b1}
                                                             : dev_rd_addr_reg;
                    end
                    PH_RADDR:    phase_next = PH_RADDR_ACK;
                    PH_RADDR_ACK:
                    begin
                        byte_cnt_next = '0;
                        phase_next    = PH_READ;
                    end
                    PH_READ:
                    begin
                        if (kind_c == OP_BURST_READ && bc_c_inc < {1'b0, total_reg})
                            phase_next = PH_MACK;
                        else
                            phase_next = PH_NAK;
                    end
                    PH_MACK:
                    begin
                        byte_cnt_next = bc_c_inc[BC_W-1:0];
                        phase_next    = PH_READ;
                    end
                    PH_NAK:      phase_next = PH_STOP;
                    default:     phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // result flags of this tick
    always_comb
    begin
        prim_t p;
        p         = prim_of(ph_c);
        rd_valid  = busy_c && (p == PR_READ) && (sub_c == 2'd0) && (bit_c == 3'd7);
        ack_valid = busy_c && (p == PR_CHECK) && (sub_c == 2'd1);
        done_flag = busy_c && (p == PR_STOP) && (sub_c == 2'd2);
        bc_ext    = {4'd0, bc_c};
        out_word  = '0;
        out_word[0]     = scl_next;
        out_word[1]     = sda_next;
        out_word[2]     = busy_c;
        out_word[3]     = rd_valid;
        out_word[11:4]  = rd_valid ? shift_next : 8'd0;
        out_word[15:12] = rd_valid ? bc_ext[3:0] : 4'd0;
        out_word[16]    = ack_valid;
        out_word[17]    = ack_valid && in_sda;
        out_word[18]    = done_flag;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_wr_addr_reg <= 8'd0;
            dev_rd_addr_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WRITE_ADDR: dev_wr_addr_reg <= cfg_data;
                CFG_READ_ADDR:  dev_rd_addr_reg <= cfg_data;
                default:        dev_wr_addr_reg <= dev_wr_addr_reg;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            sub_reg      <= 2'd0;
            bit_reg      <= 3'd0;
            byte_cnt_reg <= '0;
            shift_reg    <= 8'd0;
            kind_reg     <= OP_TICK;
            slave_reg    <= 7'd0;
            regaddr_reg  <= 8'd0;
            wdata_reg    <= 8'd0;
            total_reg    <= '0;
            load_cnt_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            sub_reg      <= sub_next;
            bit_reg      <= bit_next;
            byte_cnt_reg <= byte_cnt_next;
            shift_reg    <= shift_next;
            kind_reg     <= kind_next;
            slave_reg    <= slave_next;
            regaddr_reg  <= regaddr_next;
            wdata_reg    <= wdata_next;
            total_reg    <= total_next;
            load_cnt_reg <= load_cnt_next;
        end
    end

    // burst buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (step && buf_wr_en)
            buf_mem[buf_wr_addr] <= buf_wr_data;
        buf_rd_data_reg <= buf_mem[buf_rd_addr];
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (step)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            m_data_reg <= out_word;
    end

endmodule

FILE: bench/testbench.sv
// testbench for the i2c master core: tick stimulus, line prediction and result checking
`timescale 1ns / 100ps

module testbench
    import i2cm_pkg::*;
();

    localparam int DEPTH       = 16;
    localparam int TOTAL_WORDS = 950;

    // operation codes outside the defined set, the core treats them as a tick
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    // one predicted output word
    typedef struct {
        bit       scl;
        bit       sda;
        bit       busy;
        bit       rd_valid;
        bit [7:0] rd_data;
        bit [3:0] rd_index;
        bit       ack_valid;
        bit       ack_level;
        bit       stop_done;
    } line_word_t;

    // scoreboard: follows the line sequencer word by word and holds the predicted outputs
    class bus_line_scoreboard;
        bit [7:0]   wr_addr;
        bit [7:0]   rd_addr;
        phase_t     ph;
        bit         scl;
        bit         sda;
        bit [1:0]   sub;
        bit [3:0]   bitc;
        bit [4:0]   bytec;
        bit [7:0]   shreg;
        bit [2:0]   kind;
        bit [6:0]   slave;
        bit [7:0]   regad;
        bit [7:0]   wdat;
        bit [4:0]   total;
        bit [4:0]   loads;
        bit [7:0]   mem [DEPTH];
        bit         written [DEPTH];
        line_word_t expected_lines [$];
        int         errors;
        int         words;
        int         results;
        int         started [8];
        int         loads_done;
        int         bytes_in;
        int         acks;
        int         stops;

        function new();
            wr_addr = 8'h00;
            rd_addr = 8'h01;
            ph      = PH_IDLE;
            scl     = 1'b1;
            sda     = 1'b1;
            sub     = '0;
            bitc    = '0;
            bytec   = '0;
            shreg   = '0;
            kind    = '0;
            slave   = '0;
            regad   = '0;
            wdat    = '0;
            total   = '0;
            loads   = '0;
            foreach (written[i])
                written[i] = 1'b0;
        endfunction

        function void set_address(logic idx, logic [7:0] value);
            if (idx == CFG_WRITE_ADDR)
                wr_addr = value;
            else
                rd_addr = value;
        endfunction

        function bit idle();
            return ph == PH_IDLE;
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        // burst bytes that may be sent: entries written in a row from the first
        function int written_run();
            int n;
            n = 0;
            while (n < DEPTH && written[n])
                n++;
            return n;
        endfunction

        function void enter_phase(phase_t target, bit [7:0] value);
            ph    = target;
            sub   = '0;
            bitc  = '0;
            shreg = value;
        endfunction

        // one accepted tick word: start, load, then the line action of this tick
        function void accept_word(logic [2:0] op, logic [31:0] d);
            line_word_t r;
            bit [1:0]   t;
            bit         finished;
            bit         again;
            bit [4:0]   len;
            r        = '{default: 0};
            finished = 1'b0;
            again    = 1'b0;
            words++;
            if (ph == PH_IDLE)
            begin
                if (op == OP_LOAD)
                begin
                    if (loads < DEPTH)
                    begin
                        mem[loads[3:0]]     = d[22:15];
                        written[loads[3:0]] = 1'b1;
                        loads++;
                    end
                    loads_done++;
                end
                else if (op >= OP_REG_WRITE && op <= OP_BURST_READ)
                begin
                    len   = d[27:23];
                    kind  = op;
                    slave = d[6:0];
                    regad = d[14:7];
                    wdat  = d[22:15];
                    total = (len == 0 || len > DEPTH) ? 5'(DEPTH) : len;
                    bytec = '0;
                    if (op == OP_BURST_WRITE)
                        loads = '0;
                    started[op]++;
                    enter_phase(PH_START1, 8'h00);
                end
            end
            if (ph != PH_IDLE)
            begin
                r.busy = 1'b1;
                t      = sub;
                case (ph)
                    PH_START1, PH_START2:
                    begin
                        if (t == 0)
                            sda = 1'b1;
                        else if (t == 1)
                            scl = 1'b1;
                        else if (t == 2)
                            sda = 1'b0;
                        else
                        begin
                            scl      = 1'b0;
                            finished = 1'b1;
                        end
                    end
                    PH_ADDR, PH_REG, PH_DATA, PH_RADDR:
                    begin
                        if (t == 0)
                            sda = shreg[7];
                        else if (t == 1)
                            scl = 1'b1;
                        else
                        begin
                            scl   = 1'b0;
                            shreg = shreg << 1;
                            if (bitc >= 7)
                                finished = 1'b1;
                            else
                            begin
                                bitc++;
                                again = 1'b1;
                            end
                        end
                    end
                    PH_ADDR_ACK, PH_REG_ACK, PH_DATA_ACK, PH_RADDR_ACK:
                    begin
                        if (t == 0)
                            sda = 1'b1;
                        else if (t == 1)
                        begin
                            scl         = 1'b1;
                            r.ack_valid = 1'b1;
                            r.ack_level = d[28];
                            acks++;
                        end
                        else
                        begin
                            scl      = 1'b0;
                            finished = 1'b1;
                        end
                    end
                    PH_READ:
                    begin
                        if (t == 0)
                        begin
                            if (bitc == 0)
                                sda = 1'b1;
                            scl   = 1'b1;
                            shreg = {shreg[6:0], d[28]};
                            if (bitc >= 7)
                            begin
                                r.rd_valid = 1'b1;
                                r.rd_data  = shreg;
                                r.rd_index = bytec[3:0];
                                bytes_in++;
                                if (kind == OP_BURST_READ && bytec < DEPTH)
                                begin
                                    mem[bytec[3:0]]     = shreg;
                                    written[bytec[3:0]] = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            scl = 1'b0;
                            if (bitc >= 7)
                                finished = 1'b1;
                            else
                            begin
                                bitc++;
                                again = 1'b1;
                            end
                        end
                    end
                    PH_MACK, PH_NAK:
                    begin
                        if (t == 0)
                            sda = (ph == PH_NAK);
                        else if (t == 1)
                            scl = 1'b1;
                        else
                        begin
                            scl      = 1'b0;
                            finished = 1'b1;
                        end
                    end
                    default:
                    begin
                        // stop, also the full stop in the middle of a register read
                        if (t == 0)
                            sda = 1'b0;
                        else if (t == 1)
                            scl = 1'b1;
                        else
                        begin
                            sda         = 1'b1;
                            r.stop_done = 1'b1;
                            stops++;
                            finished    = 1'b1;
                        end
                    end
                endcase
                if (finished)
                begin
                    case (ph)
                        PH_START1:
                            enter_phase(PH_ADDR, (kind == OP_REG_WRITE || kind == OP_REG_READ)
                                                 ? {slave, 1'b0} : wr_addr);
                        PH_ADDR:      enter_phase(PH_ADDR_ACK, 8'h00);
                        PH_ADDR_ACK:  enter_phase(PH_REG, regad);
                        PH_REG:       enter_phase(PH_REG_ACK, 8'h00);
                        PH_REG_ACK:
                        begin
                            bytec = '0;
                            if (kind == OP_REG_WRITE)
                                enter_phase(PH_DATA, wdat);
                            else if (kind == OP_BURST_WRITE)
                                enter_phase(PH_DATA, mem[0]);
                            else if (kind == OP_REG_READ)
                                enter_phase(PH_MIDSTOP, 8'h00);
                            else
                                enter_phase(PH_START2, 8'h00);
                        end
                        PH_DATA:      enter_phase(PH_DATA_ACK, 8'h00);
                        PH_DATA_ACK:
                        begin
                            bytec++;
                            if (kind == OP_BURST_WRITE && bytec < total)
                                enter_phase(PH_DATA, mem[bytec[3:0]]);
                            else
                                enter_phase(PH_STOP, 8'h00);
                        end
                        PH_MIDSTOP:   enter_phase(PH_START2, 8'h00);
                        PH_START2:
                            enter_phase(PH_RADDR, (kind == OP_REG_READ)
                                                  ? {slave, 1'b1} : rd_addr);
                        PH_RADDR:     enter_phase(PH_RADDR_ACK, 8'h00);
                        PH_RADDR_ACK:
                        begin
                            bytec = '0;
                            enter_phase(PH_READ, 8'h00);
                        end
                        PH_READ:
                        begin
                            if (kind == OP_BURST_READ && int'(bytec) + 1 < int'(total))
                                enter_phase(PH_MACK, 8'h00);
                            else
                                enter_phase(PH_NAK, 8'h00);
                        end
                        PH_MACK:
                        begin
                            bytec++;
                            enter_phase(PH_READ, 8'h00);
                        end
                        PH_NAK:       enter_phase(PH_STOP, 8'h00);
                        default:      enter_phase(PH_IDLE, 8'h00);
                    endcase
                end
                else if (again)
                    sub = '0;
                else
                    sub = t + 2'd1;
            end
            r.scl = scl;
            r.sda = sda;
            expected_lines.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        // compares one output word against the oldest prediction
        task check_word(logic [23:0] m);
            line_word_t w;
            results++;
            if (expected_lines.size() == 0)
            begin
                report($sformatf("output word %0d arrived with nothing predicted", results));
                return;
            end
            w = expected_lines.pop_front();
            if (m[0] !== w.scl)
                report($sformatf("word %0d scl_level %b, predicted %b", results, m[0], w.scl));
            if (m[1] !== w.sda)
                report($sformatf("word %0d sda_level %b, predicted %b", results, m[1], w.sda));
            if (m[2] !== w.busy)
                report($sformatf("word %0d busy %b, predicted %b", results, m[2], w.busy));
            if (m[3] !== w.rd_valid)
                report($sformatf("word %0d read_valid %b, predicted %b", results, m[3],
                                 w.rd_valid));
            if (m[11:4] !== w.rd_data)
                report($sformatf("word %0d read_data %h, predicted %h", results, m[11:4],
                                 w.rd_data));
            if (m[15:12] !== w.rd_index)
                report($sformatf("word %0d read_index %0d, predicted %0d", results, m[15:12],
                                 w.rd_index));
            if (m[16] !== w.ack_valid)
                report($sformatf("word %0d ack_valid %b, predicted %b", results, m[16],
                                 w.ack_valid));
            if (m[17] !== w.ack_level)
                report($sformatf("word %0d ack_level %b, predicted %b", results, m[17],
                                 w.ack_level));
            if (m[18] !== w.stop_done)
                report($sformatf("word %0d done %b, predicted %b", results, m[18], w.stop_done));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;

    // no idling on either side while set
    bit steady     = 1'b0;
    // asks the receiver for its one long hold-off
    bit hold_armed = 1'b0;

    bus_line_scoreboard bus_lines = new();

    i2c_master_register_access_core #(
        .BURST_DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever
            #10 clk = ~clk;
    end

    // overall limit, far above the slowest correct run
    initial
    begin
        #5_000_000;
        $display("FAIL i2c_master_register_access_core");
        $finish;
    end

    // tdata layout: sda_in at bit 28, burst_length, write_data, register, slave from bit 0
    function automatic logic [31:0] pack_word(logic [6:0] sa, logic [7:0] ra, logic [7:0] wd,
                                              logic [4:0] len, logic sdi);
        return {3'b000, sdi, len, wd, ra, sa};
    endfunction

    function automatic logic [31:0] rand_word(logic sdi);
        logic [31:0] rnd;
        rnd = $urandom;
        return {3'b000, sdi, rnd[24:0]};
    endfunction

    // mostly short bursts, now and then a long or saturating one
    function automatic logic [4:0] pick_length();
        int p;
        p = $urandom_range(99);
        if (p < 82)
            return 5'($urandom_range(1, 3));
        if (p < 92)
            return 5'($urandom_range(4, DEPTH));
        if (p < 96)
            return 5'd0;
        return 5'($urandom_range(DEPTH + 1, 31));
    endfunction

    function automatic logic [7:0] pick_addr();
        int p;
        p = $urandom_range(9);
        if (p < 2)
            return 8'h00;
        if (p < 4)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // offers one word, with random gaps ahead of it, and notes it once taken
    task automatic send_word(input logic [2:0] op, input logic [31:0] d);
        while (!steady && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        bus_lines.accept_word(op, d);
    endtask

    // ticks until the transfer ends; sda held low (0), high (1) or random (2)
    task automatic tick_to_idle(input int sda_mode, input int noise_pct);
        logic [2:0] op;
        logic       sdi;
        while (!bus_lines.idle())
        begin
            sdi = (sda_mode == 2) ? 1'($urandom_range(1)) : sda_mode[0];
            op  = OP_TICK;
            // requests while busy are ignored and act as a tick
            if ($urandom_range(99) < noise_pct)
                op = 3'($urandom_range(7));
            send_word(op, rand_word(sdi));
        end
    endtask

    task automatic transfer(input logic [2:0] op, input logic [31:0] d, input int sda_mode);
        send_word(op, d);
        tick_to_idle(sda_mode, 8);
    endtask

    // sender stops and waits for every predicted word to come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (bus_lines.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        bus_lines.set_address(idx, value);
    endtask

    // address registers change only with the bus idle and the output drained
    task automatic reconfigure(input logic [7:0] wa, input logic [7:0] ra);
        tick_to_idle(2, 8);
        drain();
        write_reg(CFG_WRITE_ADDR, wa);
        write_reg(CFG_READ_ADDR, ra);
        cfg_valid <= 1'b0;
    endtask

    // receiver: checks every word taken, stalls at random, holds off once for a long stretch
    initial
    begin
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                bus_lines.check_word(m_tdata);
            if (hold_armed && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 21);
        end
    end

    // stimulus
    initial
    begin
        int          pick;
        int          n;
        int          avail;
        int          eff;
        logic [2:0]  op;
        logic [31:0] d;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of both address registers first
        reconfigure(8'hFF, 8'h00);

        // idle ticks, unknown operations included
        send_word(OP_TICK, pack_word(7'h7F, 8'hFF, 8'hFF, 5'h1F, 1'b1));
        send_word(OP_SPARE6, pack_word(7'h00, 8'h00, 8'h00, 5'h00, 1'b0));
        send_word(OP_SPARE7, pack_word(7'h7F, 8'hFF, 8'hFF, 5'h1F, 1'b1));

        // no idling on either side through the single accesses
        steady = 1'b1;
        // single write with all ones, target never acknowledges
        transfer(OP_REG_WRITE, pack_word(7'h7F, 8'hFF, 8'hFF, 5'h1F, 1'b1), 1);
        // single read with the line held low
        transfer(OP_REG_READ, pack_word(7'h00, 8'h00, 8'h00, 5'h00, 1'b0), 0);
        steady = 1'b0;

        // three loaded bytes sent as a burst
        send_word(OP_LOAD, pack_word(7'h00, 8'h00, 8'h00, 5'h00, 1'b0));
        send_word(OP_LOAD, pack_word(7'h7F, 8'hFF, 8'hFF, 5'h1F, 1'b1));
        send_word(OP_LOAD, pack_word(7'h2A, 8'h3C, 8'h5A, 5'h03, 1'b0));
        transfer(OP_BURST_WRITE, pack_word(7'h11, 8'h80, 8'h00, 5'd3, 1'b0), 2);

        // waits here for every outstanding word before the address change
        reconfigure(8'h00, 8'hFF);

        // one-byte burst read: straight to nak; a load and a start while busy are ignored
        send_word(OP_BURST_READ, pack_word(7'h55, 8'h01, 8'h00, 5'd1, 1'b0));
        send_word(OP_LOAD, pack_word(7'h00, 8'h00, 8'hC3, 5'd1, 1'b1));
        send_word(OP_BURST_WRITE, pack_word(7'h00, 8'h00, 8'h00, 5'd2, 1'b0));
        tick_to_idle(2, 0);
        // oversized length saturates and fills the whole buffer; the receiver holds off
        // for a long stretch while ticks are still offered and the core's input stalls
        hold_armed = 1'b1;
        transfer(OP_BURST_READ, pack_word(7'h00, 8'h40, 8'h00, 5'd17, 1'b0), 2);

        // random part up to the word budget
        while (bus_lines.words < TOTAL_WORDS)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                // idle ticks and unknown codes
                case ($urandom_range(2))
                    0:       op = OP_TICK;
                    1:       op = OP_SPARE6;
                    default: op = OP_SPARE7;
                endcase
                send_word(op, rand_word(1'($urandom_range(1))));
            end
            else if (pick < 24)
            begin
                // load runs, now and then past the end of the buffer
                n = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 4);
                repeat (n) send_word(OP_LOAD, rand_word(1'($urandom_range(1))));
            end
            else if (pick < 30)
                reconfigure(pick_addr(), pick_addr());
            else
            begin
                op = 3'($urandom_range(OP_REG_WRITE, OP_BURST_READ));
                d  = rand_word(1'($urandom_range(1)));
                d[27:23] = pick_length();
                if (op == OP_BURST_WRITE)
                begin
                    // never send a buffer entry that was not written
                    if (bus_lines.written_run() == 0)
                        send_word(OP_LOAD, rand_word(1'($urandom_range(1))));
                    avail = bus_lines.written_run();
                    eff   = (d[27:23] == 0 || d[27:23] > DEPTH) ? DEPTH : d[27:23];
                    if (eff > avail)
                        d[27:23] = 5'($urandom_range(1, avail));
                end
                transfer(op, d, 2);
            end
        end

        drain();
        if (bus_lines.pending() != 0)
            bus_lines.report($sformatf("%0d predicted words never came out",
                                       bus_lines.pending()));

        $display("ran %0d words: %0d register writes, %0d register reads,",
                 bus_lines.words, bus_lines.started[OP_REG_WRITE],
                 bus_lines.started[OP_REG_READ]);
        $display("  %0d burst writes, %0d burst reads, %0d loads",
                 bus_lines.started[OP_BURST_WRITE], bus_lines.started[OP_BURST_READ],
                 bus_lines.loads_done);
        $display("%0d bytes received, %0d acknowledge samples, %0d stops, %0d mismatches",
                 bus_lines.bytes_in, bus_lines.acks, bus_lines.stops, bus_lines.errors);
        if (bus_lines.errors == 0)
            $display("PASS i2c_master_register_access_core");
        else
            $display("FAIL i2c_master_register_access_core");
        $finish;
    end

endmodule

FILE: files.f
design/i2cm_pkg.sv
design/i2c_master_register_access_core.sv
bench/testbench.sv
